@@ design/cdc_pkg.sv @@
package cdc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CNT_W   = 16;
	localparam int DIFF_W  = 22;
	localparam int STAT_W  = 2;
	localparam int ACT_W   = 3;
	// day number width: (16383 + 400) * 365.25 stays below 2**23
	localparam int DN_W    = 23;
	localparam int YY_W    = 15;
	localparam int Q_W     = 8;

	localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_NEXT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PREV    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_COMPARE = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LIMIT   = 2'd2;

	typedef logic [2:0] alu_op_t;
	localparam alu_op_t OP_ADD    = 3'd0;
	localparam alu_op_t OP_SUB    = 3'd1;
	localparam alu_op_t OP_MUL365 = 3'd2;
	localparam alu_op_t OP_DIV100 = 3'd3;
	localparam alu_op_t OP_MUL100 = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [CNT_W-1:0]   count;
	} req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [DIFF_W-1:0]  diff;
		logic               later;
		logic [STAT_W-1:0]  status;
	} rsp_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days before month index mm, counting from March
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] mm);
		logic [8:0] n;
		case (mm)
			4'd0:    n = 9'd0;
			4'd1:    n = 9'd31;
			4'd2:    n = 9'd61;
			4'd3:    n = 9'd92;
			4'd4:    n = 9'd122;
			4'd5:    n = 9'd153;
			4'd6:    n = 9'd184;
			4'd7:    n = 9'd214;
			4'd8:    n = 9'd245;
			4'd9:    n = 9'd275;
			4'd10:   n = 9'd306;
			4'd11:   n = 9'd337;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

@@ design/cdc_alu.sv @@
module cdc_alu (
	input  cdc_pkg::alu_op_t          op,
	input  logic [cdc_pkg::DN_W-1:0]  a,
	input  logic [cdc_pkg::DN_W-1:0]  b,
	output logic [cdc_pkg::DN_W-1:0]  res,
	output logic                      borrow
);
	import cdc_pkg::*;

	logic [27:0]   prod_div;
	logic [23:0]   prod_365;
	logic [15:0]   prod_100;
	logic [DN_W:0] diff_ext;

	// floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
	assign prod_div = 28'(a[YY_W-1:0]) * 28'd5243;
	assign prod_365 = 24'(a[YY_W-1:0]) * 24'd365;
	assign prod_100 = 16'(a[Q_W-1:0]) * 16'd100;
	assign diff_ext = {1'b0, a} - {1'b0, b};

	always_comb begin
		borrow = 1'b0;
		unique case (op)
			OP_ADD:    res = a + b;
			OP_SUB: begin
				res    = diff_ext[DN_W-1:0];
				borrow = diff_ext[DN_W];
			end
			OP_MUL365: res = prod_365[DN_W-1:0];
			OP_DIV100: res = DN_W'(prod_div[27:19]);
			OP_MUL100: res = DN_W'(prod_100);
			default:   res = '0;
		endcase
	end

endmodule

@@ design/cdc_core.sv @@
module cdc_core #(
	parameter int MAX_YEAR    = 9999,
	parameter int COUNT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cdc_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cdc_pkg::rsp_t  rsp
);
	import cdc_pkg::*;

	localparam int DL_W = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
	localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_LEAP0 = 5'd2;
	localparam logic [4:0] S_LEAP1 = 5'd3;
	localparam logic [4:0] S_CHECK = 5'd4;
	localparam logic [4:0] S_STEP  = 5'd5;
	localparam logic [4:0] S_ADV   = 5'd6;
	localparam logic [4:0] S_PREV0 = 5'd7;
	localparam logic [4:0] S_PREV1 = 5'd8;
	localparam logic [4:0] S_N0    = 5'd9;
	localparam logic [4:0] S_N1    = 5'd10;
	localparam logic [4:0] S_N2    = 5'd11;
	localparam logic [4:0] S_N3    = 5'd12;
	localparam logic [4:0] S_N4    = 5'd13;
	localparam logic [4:0] S_N5    = 5'd14;
	localparam logic [4:0] S_N6    = 5'd15;
	localparam logic [4:0] S_DIFF0 = 5'd16;
	localparam logic [4:0] S_DIFF1 = 5'd17;
	localparam logic [4:0] S_DONE  = 5'd18;

	logic [4:0]         state_q, ret_q;
	logic [ACT_W-1:0]   act_q;
	logic [YEAR_W-1:0]  iy_q, cur_y_q, lyear_q;
	logic [MONTH_W-1:0] im_q, cur_m_q;
	logic [DAY_W-1:0]   id_q, cur_d_q;
	logic [DL_W-1:0]    cnt_q, days_left_q;
	logic [Q_W-1:0]     q_q;
	logic [YY_W-1:0]    yy_q;
	logic [DN_W-1:0]    acc_q, dn_a_q;
	logic               sel_q, leap_q, later_q;
	logic [STAT_W-1:0]  status_q;
	logic [DIFF_W-1:0]  diff_q;

	alu_op_t            alu_op;
	logic [DN_W-1:0]    alu_a, alu_b, alu_res;
	logic               alu_borrow;

	logic [YEAR_W-1:0]  dy;
	logic [MONTH_W-1:0] dm, mm;
	logic [DAY_W-1:0]   dd;
	logic               at_top, at_bottom, in_ok, c100;
	logic [DIFF_W-1:0]  diff_sat;

	cdc_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	assign dy = sel_q ? iy_q : cur_y_q;
	assign dm = sel_q ? im_q : cur_m_q;
	assign dd = sel_q ? id_q : cur_d_q;
	assign mm = (dm <= 4'd2) ? dm + 4'd9 : dm - 4'd3;

	assign at_top    = (cur_y_q == MaxYear) && (cur_m_q == 4'd12) && (cur_d_q == 5'd31);
	assign at_bottom = (cur_y_q == '0) && (cur_m_q == 4'd1) && (cur_d_q == 5'd1);
	assign in_ok     = (iy_q <= MaxYear) && (im_q >= 4'd1) && (im_q <= 4'd12)
	                && (id_q >= 5'd1) && (id_q <= month_len(im_q, leap_q));
	assign c100      = (alu_res == DN_W'(lyear_q));
	assign diff_sat  = alu_res[DN_W-1] ? '1 : alu_res[DIFF_W-1:0];

	always_comb begin
		alu_op = OP_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_LEAP0: begin
				alu_op = OP_DIV100;
				alu_a  = DN_W'(lyear_q);
			end
			S_LEAP1: begin
				alu_op = OP_MUL100;
				alu_a  = DN_W'(q_q);
			end
			S_N0: begin
				alu_a = DN_W'(dy);
				alu_b = (dm <= 4'd2) ? DN_W'(399) : DN_W'(400);
			end
			S_N1: begin
				alu_op = OP_MUL365;
				alu_a  = DN_W'(yy_q);
			end
			S_N2: begin
				alu_a = acc_q;
				alu_b = DN_W'(yy_q[YY_W-1:2]);
			end
			S_N3: begin
				alu_op = OP_DIV100;
				alu_a  = DN_W'(yy_q);
			end
			S_N4: begin
				alu_op = OP_SUB;
				alu_a  = acc_q;
				alu_b  = DN_W'(q_q);
			end
			S_N5: begin
				alu_a = acc_q;
				alu_b = DN_W'(q_q[Q_W-1:2]);
			end
			S_N6: begin
				alu_a = acc_q;
				alu_b = DN_W'(cum_days(mm)) + DN_W'(dd) - DN_W'(1);
			end
			S_DIFF0: begin
				alu_op = OP_SUB;
				alu_a  = dn_a_q;
				alu_b  = acc_q;
			end
			S_DIFF1: begin
				alu_op = OP_SUB;
				alu_a  = acc_q;
				alu_b  = dn_a_q;
			end
			default: begin
				alu_op = OP_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cur_y_q     <= YEAR_W'(2000);
			cur_m_q     <= 4'd1;
			cur_d_q     <= 5'd1;
			days_left_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (act_q)
						ACT_LOAD, ACT_COMPARE: begin
							ret_q   <= S_CHECK;
							state_q <= S_LEAP0;
						end
						ACT_NEXT: begin
							days_left_q <= DL_W'(1);
							state_q     <= S_STEP;
						end
						ACT_ADVANCE: begin
							days_left_q <= cnt_q;
							state_q     <= S_STEP;
						end
						ACT_PREV: state_q <= S_PREV0;
						default:  state_q <= S_DONE;
					endcase
				end
				S_LEAP0: state_q <= S_LEAP1;
				S_LEAP1: state_q <= ret_q;
				S_CHECK: begin
					if (act_q == ACT_COMPARE && in_ok) begin
						state_q <= S_N0;
					end else begin
						if (act_q == ACT_LOAD && in_ok) begin
							cur_y_q <= iy_q;
							cur_m_q <= im_q;
							cur_d_q <= id_q;
						end
						state_q <= S_DONE;
					end
				end
				S_STEP: begin
					priority if (cur_y_q > MaxYear || (days_left_q != '0 && at_top)) begin
						cur_y_q     <= MaxYear;
						cur_m_q     <= 4'd12;
						cur_d_q     <= 5'd31;
						days_left_q <= '0;
						state_q     <= S_DONE;
					end else if (days_left_q == '0) begin
						state_q <= S_DONE;
					end else if (cur_m_q == 4'd2) begin
						ret_q   <= S_ADV;
						state_q <= S_LEAP0;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					priority if (cur_d_q < month_len(cur_m_q, leap_q)) begin
						cur_d_q <= cur_d_q + 5'd1;
					end else if (cur_m_q < 4'd12) begin
						cur_m_q <= cur_m_q + 4'd1;
						cur_d_q <= 5'd1;
					end else begin
						cur_y_q <= cur_y_q + 14'd1;
						cur_m_q <= 4'd1;
						cur_d_q <= 5'd1;
					end
					days_left_q <= days_left_q - DL_W'(1);
					state_q     <= S_STEP;
				end
				S_PREV0: begin
					priority if (at_bottom) begin
						state_q <= S_DONE;
					end else if (cur_d_q > 5'd1) begin
						cur_d_q <= cur_d_q - 5'd1;
						state_q <= S_DONE;
					end else if (cur_m_q == 4'd3) begin
						ret_q   <= S_PREV1;
						state_q <= S_LEAP0;
					end else begin
						state_q <= S_PREV1;
					end
				end
				S_PREV1: begin
					if (cur_m_q > 4'd1) begin
						cur_m_q <= cur_m_q - 4'd1;
						cur_d_q <= month_len(cur_m_q - 4'd1, leap_q);
					end else begin
						cur_y_q <= cur_y_q - 14'd1;
						cur_m_q <= 4'd12;
						cur_d_q <= 5'd31;
					end
					state_q <= S_DONE;
				end
				S_N0: state_q <= S_N1;
				S_N1: state_q <= S_N2;
				S_N2: state_q <= S_N3;
				S_N3: state_q <= S_N4;
				S_N4: state_q <= S_N5;
				S_N5: state_q <= S_N6;
				S_N6: state_q <= sel_q ? S_DIFF0 : S_N0;
				S_DIFF0: state_q <= alu_borrow ? S_DIFF1 : S_DONE;
				S_DIFF1: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q <= req.action;
				iy_q  <= req.year;
				im_q  <= req.month;
				id_q  <= req.day;
				cnt_q <= req.count[DL_W-1:0];
			end
			S_DISP: begin
				status_q <= STAT_OK;
				diff_q   <= '0;
				later_q  <= 1'b0;
				lyear_q  <= iy_q;
			end
			S_LEAP0: q_q <= alu_res[Q_W-1:0];
			S_LEAP1: begin
				leap_q <= (lyear_q[1:0] == 2'b00) && (!c100 || q_q[1:0] == 2'b00);
			end
			S_CHECK: begin
				sel_q <= 1'b0;
				if (!in_ok) begin
					status_q <= STAT_INVALID;
				end
			end
			S_STEP: begin
				lyear_q <= cur_y_q;
				if (cur_y_q > MaxYear || (days_left_q != '0 && at_top)) begin
					status_q <= STAT_LIMIT;
				end
			end
			S_PREV0: begin
				lyear_q <= cur_y_q;
				if (at_bottom) begin
					status_q <= STAT_LIMIT;
				end
			end
			S_N0: yy_q <= alu_res[YY_W-1:0];
			S_N1, S_N2, S_N4, S_N5: acc_q <= alu_res;
			S_N3: q_q <= alu_res[Q_W-1:0];
			S_N6: begin
				if (sel_q) begin
					acc_q <= alu_res;
				end else begin
					dn_a_q <= alu_res;
					sel_q  <= 1'b1;
				end
			end
			S_DIFF0: begin
				if (!alu_borrow) begin
					diff_q  <= diff_sat;
					later_q <= (alu_res != '0);
				end
			end
			S_DIFF1: diff_q <= diff_sat;
			default: begin
				act_q <= act_q;
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);

	always_comb begin
		rsp.year   = cur_y_q;
		rsp.month  = cur_m_q;
		rsp.day    = cur_d_q;
		rsp.diff   = diff_q;
		rsp.later  = later_q;
		rsp.status = status_q;
	end

endmodule

@@ design/calendar_date_counter.sv @@
// Channel   Signals                                          Transfer when
// input     in_valid, in_ready, action, in_year, in_month,   in_valid && in_ready
//           in_day, day_count
// output    out_valid, out_ready, out_year, out_month,       out_valid && out_ready
//           out_day, days_between, is_later, status
//
// Path from input transfer to the result in the output register: load and
//   compare check the date after a leap-year pass; an unused code goes
//   straight to done; previous day moves back a day, crosses a month
//   boundary (with a leap-year pass into February) or holds at the lowest
//   date; next day and advance by n stop at the top date. Day stepping walks
//   one day per pass of the step loop, with a leap-year pass for February
//   days; compare runs two closed-form day numbers through the shared ALU.
// Reset sets the stored date to 2000-01-01 and empties the output register.
// The next item is taken while the output register holds a result; the core
// waits in its done state only when its next result is ready before that drains.
module calendar_date_counter #(
	parameter int MAX_YEAR    = 9999,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [13:0] in_year,
	input  logic [3:0]  in_month,
	input  logic [4:0]  in_day,
	input  logic [15:0] day_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [21:0] days_between,
	output logic        is_later,
	output logic [1:0]  status
);
	import cdc_pkg::*;

	req_t req;
	rsp_t rsp;
	logic rsp_valid, rsp_ready;
	logic out_valid_q;
	rsp_t out_q;

	// pack the input fields for the sequencer
	always_comb begin
		req.action = action;
		req.year   = in_year;
		req.month  = in_month;
		req.day    = in_day;
		req.count  = day_count;
	end

	cdc_core #(
		.MAX_YEAR    (MAX_YEAR),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// output register: take a finished result when empty or being drained
	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	// hold the payload while the downstream side stalls
	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_q <= rsp;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_year     = out_q.year;
	assign out_month    = out_q.month;
	assign out_day      = out_q.day;
	assign days_between = out_q.diff;
	assign is_later     = out_q.later;
	assign status       = out_q.status;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import cdc_pkg::*;

	// Block configuration; the predictor uses the same limits.
	localparam int unsigned TOP_YEAR   = 9999;
	localparam int unsigned COUNT_BITS = 16;
	// days_between saturates at the largest 22-bit value
	localparam longint DIFF_CAP = (64'd1 << DIFF_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [ACT_W-1:0]   action = '0;
	logic [YEAR_W-1:0]  in_year = '0;
	logic [MONTH_W-1:0] in_month = '0;
	logic [DAY_W-1:0]   in_day = '0;
	logic [CNT_W-1:0]   day_count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [YEAR_W-1:0]  out_year;
	logic [MONTH_W-1:0] out_month;
	logic [DAY_W-1:0]   out_day;
	logic [DIFF_W-1:0]  days_between;
	logic               is_later;
	logic [STAT_W-1:0]  status;

	// Predicted calendar state: the date the block should hold right now.
	int unsigned cal_year;
	int unsigned cal_month;
	int unsigned cal_day;

	// Results still owed by the block, oldest first.
	rsp_t pending_results[$];
	rsp_t head_result;
	int   fail_count = 0;

	// Sender burst bookkeeping and receiver stall pattern.
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	calendar_date_counter #(
		.MAX_YEAR   (TOP_YEAR),
		.COUNT_WIDTH(COUNT_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.in_year     (in_year),
		.in_month    (in_month),
		.in_day      (in_day),
		.day_count   (day_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_year    (out_year),
		.out_month   (out_month),
		.out_day     (out_day),
		.days_between(days_between),
		.is_later    (is_later),
		.status      (status)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Calendar arithmetic for the predictor
	// ------------------------------------------------------------------

	// Leap year: divisible by 4 and not by 100, or divisible by 400.
	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		case (m)
			2:          return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
		if (y > TOP_YEAR || m < 1 || m > 12 || d < 1)
			return 1'b0;
		return d <= month_days(y, m);
	endfunction

	// Serial day number. Shift the year by 400 so it never goes negative,
	// and count months from March so the leap day falls at the year's end.
	function automatic longint day_serial(int unsigned y, int unsigned m, int unsigned d);
		longint yy;
		longint mm;
		yy = longint'(y) + 400;
		if (m <= 2) begin
			yy = yy - 1;
			mm = longint'(m) + 9;
		end else begin
			mm = longint'(m) - 3;
		end
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
	endfunction

	// Inverse of day_serial: split into 400-year eras, then year of era,
	// day of year and March-based month.
	function automatic void set_from_serial(longint n);
		longint era;
		longint doe;
		longint yoe;
		longint doy;
		longint mp;
		longint mo;
		era = n / 146097;
		doe = n - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		mo  = (mp < 10) ? mp + 3 : mp - 9;
		cal_day   = int'(doy - (153 * mp + 2) / 5 + 1);
		cal_month = int'(mo);
		cal_year  = int'(yoe + era * 400 + ((mo <= 2) ? 1 : 0) - 400);
	endfunction

	// Move the held date forward; clamp at the top date and flag it.
	function automatic logic [STAT_W-1:0] step_forward(longint count);
		longint top;
		longint target;
		top    = day_serial(TOP_YEAR, 12, 31);
		target = day_serial(cal_year, cal_month, cal_day) + count;
		if (target > top) begin
			set_from_serial(top);
			return STAT_LIMIT;
		end
		set_from_serial(target);
		return STAT_OK;
	endfunction

	// Apply one request to the predicted state and build the result it owes.
	function automatic rsp_t predict_result(logic [ACT_W-1:0] act, logic [YEAR_W-1:0] y,
		logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d, logic [CNT_W-1:0] cnt);
		rsp_t   r;
		longint here;
		longint there;
		longint span;
		r = '0;
		case (act)
			ACT_LOAD: begin
				if (date_valid(32'(y), 32'(m), 32'(d))) begin
					cal_year  = 32'(y);
					cal_month = 32'(m);
					cal_day   = 32'(d);
				end else begin
					r.status = STAT_INVALID;
				end
			end
			ACT_NEXT: r.status = step_forward(1);
			ACT_PREV: begin
				// hold at the lowest date and flag the range limit
				if (cal_year == 0 && cal_month == 1 && cal_day == 1)
					r.status = STAT_LIMIT;
				else
					set_from_serial(day_serial(cal_year, cal_month, cal_day) - 1);
			end
			ACT_ADVANCE: r.status = step_forward(longint'(cnt) &
				((64'd1 << COUNT_BITS) - 1));
			ACT_COMPARE: begin
				if (date_valid(32'(y), 32'(m), 32'(d))) begin
					here  = day_serial(cal_year, cal_month, cal_day);
					there = day_serial(32'(y), 32'(m), 32'(d));
					if (here > there) begin
						r.later = 1'b1;
						span = here - there;
					end else begin
						span = there - here;
					end
					if (span > DIFF_CAP)
						span = DIFF_CAP;
					r.diff = DIFF_W'(span);
				end else begin
					r.status = STAT_INVALID;
				end
			end
			default: ; // unused codes leave everything alone
		endcase
		r.year  = YEAR_W'(cal_year);
		r.month = MONTH_W'(cal_month);
		r.day   = DAY_W'(cal_day);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Present one request at the falling edge, hold it until the transfer,
	// then log the predicted result. Between bursts, drop valid for a
	// random gap; long bursts give stretches with no idling at all.
	task automatic send_request(logic [ACT_W-1:0] act, logic [YEAR_W-1:0] y,
		logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d, logic [CNT_W-1:0] cnt);
		int gap;
		@(negedge clk);
		in_valid  <= 1'b1;
		action    <= act;
		in_year   <= y;
		in_month  <= m;
		in_day    <= d;
		day_count <= cnt;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_result(act, y, m, d, cnt));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Drop valid and hold off until every owed result has come back.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Pick a valid date, biased toward the ends of the range, century
	// years and month boundaries.
	task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
		output logic [DAY_W-1:0] d);
		int unsigned sel;
		int unsigned yr;
		int unsigned mo;
		int unsigned len;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			yr = $urandom_range(0, TOP_YEAR);
		else if (sel < 75)
			yr = $urandom_range(0, 3);
		else if (sel < 90)
			yr = $urandom_range(TOP_YEAR - 3, TOP_YEAR);
		else
			yr = $urandom_range(0, 99) * 100;
		mo  = $urandom_range(1, 12);
		len = month_days(yr, mo);
		sel = $urandom_range(0, 9);
		y = YEAR_W'(yr);
		m = MONTH_W'(mo);
		if (sel < 3)
			d = DAY_W'(len);
		else if (sel < 5)
			d = DAY_W'(1);
		else
			d = DAY_W'($urandom_range(1, len));
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Stall on a pattern of its own: always ready, coin flips, one cycle
	// in four, or mostly ready, each for a random stretch.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 80);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= (stall_left % 4 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", label, want_v, got_v);
			fail_count++;
		end
	endtask

	// Compare every result transfer with the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result %0d-%0d-%0d with nothing owed", out_year, out_month, out_day);
				fail_count++;
			end else begin
				head_result = pending_results.pop_front();
				check_field("out_year", 32'(head_result.year), 32'(out_year));
				check_field("out_month", 32'(head_result.month), 32'(out_month));
				check_field("out_day", 32'(head_result.day), 32'(out_day));
				check_field("days_between", 32'(head_result.diff), 32'(days_between));
				check_field("is_later", 32'(head_result.later), 32'(is_later));
				check_field("status", 32'(head_result.status), 32'(status));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Unused codes change nothing, so the result shows the reset date.
	task automatic test_unused_actions();
		send_request(3'd5, '1, '1, '1, '1);
		send_request(3'd7, '0, '0, '0, '0);
	endtask

	// Loads: leap rules, each field out of range, and a year above the top.
	task automatic test_loads();
		send_request(ACT_LOAD, 2000, 2, 29, 0);   // leap by the 400 rule
		send_request(ACT_LOAD, 1900, 2, 29, 0);   // century, not leap
		send_request(ACT_LOAD, 2000, 0, 10, 0);
		send_request(ACT_LOAD, 2000, 15, 1, 0);
		send_request(ACT_LOAD, 2000, 6, 0, 0);
		send_request(ACT_LOAD, 2021, 4, 31, 0);   // past a 30-day month
		send_request(ACT_LOAD, '1, 12, 31, 0);    // year above the top
	endtask

	// Single steps across year ends, into February, and at both range ends.
	task automatic test_day_steps();
		send_request(ACT_LOAD, 1999, 12, 31, 0);
		send_request(ACT_NEXT, 0, 0, 0, 0);
		send_request(ACT_PREV, 0, 0, 0, 0);
		send_request(ACT_LOAD, 2000, 3, 1, 0);
		send_request(ACT_PREV, 0, 0, 0, 0);
		send_request(ACT_LOAD, 0, 1, 1, 0);
		send_request(ACT_PREV, 0, 0, 0, 0);      // hold at the lowest date
		send_request(ACT_LOAD, TOP_YEAR, 12, 31, 0);
		send_request(ACT_NEXT, 0, 0, 0, 0);      // hold at the top date
	endtask

	// Advance by zero, by the widest count, and past the top date.
	task automatic test_advance();
		send_request(ACT_LOAD, 0, 1, 1, 0);
		send_request(ACT_ADVANCE, 0, 0, 0, 0);
		send_request(ACT_ADVANCE, 0, 0, 0, '1);
		send_request(ACT_LOAD, TOP_YEAR, 12, 1, 0);
		send_request(ACT_ADVANCE, 0, 0, 0, 100);
	endtask

	// Compare across the full span both ways, equal dates, and a bad date.
	task automatic test_compare();
		send_request(ACT_COMPARE, 0, 1, 1, 0);
		send_request(ACT_LOAD, 0, 1, 1, 0);
		send_request(ACT_COMPARE, TOP_YEAR, 12, 31, 0);
		send_request(ACT_COMPARE, 0, 1, 1, 0);
		send_request(ACT_COMPARE, 2100, 2, 29, 0);
	endtask

	// Mostly well-formed traffic with random dates and counts, plus raw
	// field noise. Halfway through, pause until the block has drained.
	task automatic test_random_traffic(int num_items);
		int unsigned        sel;
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		logic [CNT_W-1:0]   cnt;
		for (int i = 0; i < num_items; i++) begin
			if (i == num_items / 2)
				wait_results_drained();
			sel = $urandom_range(0, 99);
			y   = YEAR_W'($urandom_range(0, 16383));
			m   = MONTH_W'($urandom_range(0, 15));
			d   = DAY_W'($urandom_range(0, 31));
			cnt = CNT_W'($urandom_range(0, 65535));
			if (sel < 14) begin
				pick_date(y, m, d);
				send_request(ACT_LOAD, y, m, d, cnt);
			end else if (sel < 17) begin
				send_request(ACT_LOAD, y, m, d, cnt);
			end else if (sel < 37) begin
				send_request(ACT_NEXT, y, m, d, cnt);
			end else if (sel < 55) begin
				send_request(ACT_PREV, y, m, d, cnt);
			end else if (sel < 72) begin
				// keep counts small: the block walks one day at a time
				sel = $urandom_range(0, 99);
				if (sel < 70)
					cnt = CNT_W'($urandom_range(0, 40));
				else if (sel < 95)
					cnt = CNT_W'($urandom_range(0, 400));
				else
					cnt = CNT_W'($urandom_range(0, 2000));
				send_request(ACT_ADVANCE, y, m, d, cnt);
			end else if (sel < 95) begin
				pick_date(y, m, d);
				send_request(ACT_COMPARE, y, m, d, cnt);
			end else if (sel < 97) begin
				send_request(ACT_COMPARE, y, m, d, cnt);
			end else begin
				send_request(ACT_W'($urandom_range(5, 7)), y, m, d, cnt);
			end
		end
	endtask

	initial begin
		cal_year  = 2000;
		cal_month = 1;
		cal_day   = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unused_actions();
		test_loads();
		test_day_steps();
		wait_results_drained();
		test_advance();
		test_compare();
		test_random_traffic(600);

		// Drain, then give a stray result time to show up.
		wait_results_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
design/cdc_pkg.sv
design/cdc_alu.sv
design/cdc_core.sv
design/calendar_date_counter.sv
sim/testbench.sv
